// File: design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked only while out of reset.
`define AAR_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Checked at every edge, reset included.
`define AAR_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define AAR_ASSERT(name, clk, rstn, prop)
`define AAR_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

// File: design/aar_pkg.sv
// Types and constants for the rational atan2 pipeline.
package aar_pkg;

  localparam int FRAC_BITS = 13;
  // floor(2^(FRAC_BITS+1) * ratio), ratio < 1
  localparam int QUO_BITS = FRAC_BITS + 1;
  // largest quotient: equal magnitudes give 2^14 * 25/32
  localparam logic [QUO_BITS-1:0] QUO_MAX = QUO_BITS'(12800);

  localparam int ANGLE_W = 16;
  localparam logic signed [ANGLE_W-1:0] PI_Q      = 16'sd25736;
  localparam logic signed [ANGLE_W-1:0] HALF_PI_Q = 16'sd12868;

  typedef struct packed {
    logic x_zero;
    logic y_zero;
    logic x_neg;
    logic y_neg;
    logic swap;   // |imag| >= |real|
    logic neg;    // signs of real and imag differ, imag nonzero
  } flags_t;

endpackage

// File: design/aar_sort.sv
// First stage: magnitudes, ordering and sign flags of the sample.
module aar_sort #(
  parameter int W = 16
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [W-1:0]   real_part_i,
  input  logic signed [W-1:0]   imag_part_i,
  output logic        [W-1:0]   m_o,
  output logic        [W-1:0]   n_o,
  output aar_pkg::flags_t       flags_o
);
  import aar_pkg::*;

  logic [W-1:0] a, b;
  logic [W-1:0] m_d, m_q, n_d, n_q;
  flags_t       flags_d, flags_q;

  // most negative value maps to 2^(W-1), still fits unsigned W bits
  assign a = real_part_i[W-1] ? (~real_part_i + W'(1)) : real_part_i;
  assign b = imag_part_i[W-1] ? (~imag_part_i + W'(1)) : imag_part_i;

  always_comb begin
    flags_d.x_zero = (a == '0);
    flags_d.y_zero = (b == '0);
    flags_d.x_neg  = real_part_i[W-1];
    flags_d.y_neg  = imag_part_i[W-1];
    flags_d.swap   = (b >= a);
    flags_d.neg    = (b != '0) && (real_part_i[W-1] != imag_part_i[W-1]);
    m_d = flags_d.swap ? b : a;
    n_d = flags_d.swap ? a : b;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q     <= m_d;
      n_q     <= n_d;
      flags_q <= flags_d;
    end
  end

  assign m_o     = m_q;
  assign n_o     = n_q;
  assign flags_o = flags_q;

endmodule

// File: design/aar_mult.sv
// Two stages: squares and cross product, then divisor 25m^2+7n^2 and dividend 25mn.
module aar_mult #(
  parameter int W = 16
) (
  input  logic                  clk_i,
  input  logic                  en_a_i,
  input  logic                  en_b_i,
  input  logic [W-1:0]          m_i,
  input  logic [W-1:0]          n_i,
  input  aar_pkg::flags_t       flags_i,
  output logic [2*W+3:0]        den_o,
  output logic [2*W+3:0]        rem_o,
  output aar_pkg::flags_t       flags_o
);
  import aar_pkg::*;

  localparam int PW = 2 * W;
  localparam int DW = 2 * W + 4;

  logic [PW-1:0] mm_d, mm_q, nn_d, nn_q, mn_d, mn_q;
  logic [DW-1:0] mm_x, nn_x, mn_x;
  logic [DW-1:0] den_d, den_q, rem_d, rem_q;
  flags_t        flags_a_q, flags_b_q;

  assign mm_d = PW'(m_i) * PW'(m_i);
  assign nn_d = PW'(n_i) * PW'(n_i);
  assign mn_d = PW'(m_i) * PW'(n_i);

  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      mm_q      <= mm_d;
      nn_q      <= nn_d;
      mn_q      <= mn_d;
      flags_a_q <= flags_i;
    end
  end

  assign mm_x = DW'(mm_q);
  assign nn_x = DW'(nn_q);
  assign mn_x = DW'(mn_q);

  // 25 = 16 + 8 + 1, 7 = 8 - 1
  assign den_d = (mm_x << 4) + (mm_x << 3) + mm_x + (nn_x << 3) - nn_x;
  assign rem_d = (mn_x << 4) + (mn_x << 3) + mn_x;

  always_ff @(posedge clk_i) begin
    if (en_b_i) begin
      den_q     <= den_d;
      rem_q     <= rem_d;
      flags_b_q <= flags_a_q;
    end
  end

  assign den_o   = den_q;
  assign rem_o   = rem_q;
  assign flags_o = flags_b_q;

endmodule

// File: design/aar_div_step.sv
// One restoring division step: one quotient bit per stage.
module aar_div_step #(
  parameter int W = 16
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [2*W+3:0]                 den_i,
  input  logic [2*W+3:0]                 rem_i,
  input  logic [aar_pkg::QUO_BITS-1:0]   quo_i,
  input  aar_pkg::flags_t                flags_i,
  output logic [2*W+3:0]                 den_o,
  output logic [2*W+3:0]                 rem_o,
  output logic [aar_pkg::QUO_BITS-1:0]   quo_o,
  output aar_pkg::flags_t                flags_o
);
  import aar_pkg::*;

  localparam int DW = 2 * W + 4;

  logic [DW:0]         shl, diff;
  logic                ge;
  logic [DW-1:0]       rem_d, rem_q, den_q;
  logic [QUO_BITS-1:0] quo_d, quo_q;
  flags_t              flags_q;

  // remainder stays below the divisor, so the doubled value fits DW+1 bits
  assign shl   = {rem_i, 1'b0};
  assign diff  = shl - {1'b0, den_i};
  assign ge    = (shl >= {1'b0, den_i});
  assign rem_d = ge ? diff[DW-1:0] : shl[DW-1:0];
  assign quo_d = {quo_i[QUO_BITS-2:0], ge};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q   <= den_i;
      rem_q   <= rem_d;
      quo_q   <= quo_d;
      flags_q <= flags_i;
    end
  end

  assign den_o   = den_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign flags_o = flags_q;

endmodule

// File: design/aar_angle.sv
// Last stage: rounding, sign and quadrant offset; holds the output word.
module aar_angle (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic [aar_pkg::QUO_BITS-1:0]          quo_i,
  input  aar_pkg::flags_t                       flags_i,
  output logic signed [aar_pkg::ANGLE_W-1:0]    angle_o
);
  import aar_pkg::*;

  localparam int SW = ANGLE_W + 2;

  logic [QUO_BITS:0]        quo_inc;
  logic [QUO_BITS-1:0]      q;
  logic signed [SW-1:0]     sq, pi_x, half_x, sum;
  logic signed [ANGLE_W-1:0] angle_d, angle_q;

  // round half up: (floor(2x) + 1) / 2
  assign quo_inc = {1'b0, quo_i} + (QUO_BITS + 1)'(1);
  assign q       = quo_inc[QUO_BITS:1];
  assign pi_x    = SW'(PI_Q);
  assign half_x  = SW'(HALF_PI_Q);

  always_comb begin
    sq = flags_i.neg ? -$signed(SW'(q)) : $signed(SW'(q));
    if (flags_i.swap) begin
      sum = half_x - sq;
      if (flags_i.y_neg) begin
        sum = sum - pi_x;
      end
    end else begin
      sum = sq;
      if (flags_i.x_neg) begin
        sum = flags_i.y_neg ? (sum - pi_x) : (sum + pi_x);
      end
    end
    if (flags_i.x_zero) begin
      if (flags_i.y_zero) begin
        angle_d = '0;
      end else if (flags_i.y_neg) begin
        angle_d = -HALF_PI_Q;
      end else begin
        angle_d = HALF_PI_Q;
      end
    end else begin
      angle_d = sum[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= angle_d;
    end
  end

  assign angle_o = angle_q;

endmodule

// File: design/approx_atan2_rational.sv
// Top level: rational atan2 approximation pipeline, Q3.13 radians out.
//
//   channel  valid        ready        payload
//   in       in_valid_i   in_ready_o   real_part_i, imag_part_i
//   out      out_valid_o  out_ready_i  angle_o
//
// Stages: sort, products, divisor/dividend, 14 division steps, output;
// the restoring divider sets the depth. One word per cycle without a stall.
// rst_ni clears only the stage valid bits; payload registers keep stale data.
// Each stage moves when empty or when the one after it moves, so a stall
// at the output fills empty stages before it stops the input.
`include "assert_macros.svh"

module approx_atan2_rational #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]      real_part_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      imag_part_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [aar_pkg::ANGLE_W-1:0]  angle_o
);
  import aar_pkg::*;

  localparam int W   = SAMPLE_WIDTH;
  localparam int DW  = 2 * W + 4;
  localparam int DIV0 = 3;                  // first division stage
  localparam int NST = DIV0 + QUO_BITS + 1; // total register stages
  localparam int LAST = NST - 1;

  logic [NST-1:0] v_d, v_q, en;

  logic [W-1:0]        m, n;
  flags_t              flags_sort;
  logic [DW-1:0]       den_s   [QUO_BITS+1];
  logic [DW-1:0]       rem_s   [QUO_BITS+1];
  logic [QUO_BITS-1:0] quo_s   [QUO_BITS+1];
  flags_t              flags_s [QUO_BITS+1];
  logic                quo_chk;

  // stage k loads when it is empty or its word moves on
  assign en[LAST] = !v_q[LAST] || out_ready_i;
  for (genvar k = 0; k < LAST; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end

  assign v_d = {v_q[NST-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          v_q[k] <= v_d[k];
        end
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[LAST];

  aar_sort #(.W(W)) u_sort (
    .clk_i       (clk_i),
    .en_i        (en[0]),
    .real_part_i (real_part_i),
    .imag_part_i (imag_part_i),
    .m_o         (m),
    .n_o         (n),
    .flags_o     (flags_sort)
  );

  aar_mult #(.W(W)) u_mult (
    .clk_i   (clk_i),
    .en_a_i  (en[1]),
    .en_b_i  (en[2]),
    .m_i     (m),
    .n_i     (n),
    .flags_i (flags_sort),
    .den_o   (den_s[0]),
    .rem_o   (rem_s[0]),
    .flags_o (flags_s[0])
  );

  assign quo_s[0] = '0;

  for (genvar i = 0; i < QUO_BITS; i++) begin : g_div
    aar_div_step #(.W(W)) u_step (
      .clk_i   (clk_i),
      .en_i    (en[DIV0+i]),
      .den_i   (den_s[i]),
      .rem_i   (rem_s[i]),
      .quo_i   (quo_s[i]),
      .flags_i (flags_s[i]),
      .den_o   (den_s[i+1]),
      .rem_o   (rem_s[i+1]),
      .quo_o   (quo_s[i+1]),
      .flags_o (flags_s[i+1])
    );
  end

  aar_angle u_angle (
    .clk_i   (clk_i),
    .en_i    (en[LAST]),
    .quo_i   (quo_s[QUO_BITS]),
    .flags_i (flags_s[QUO_BITS]),
    .angle_o (angle_o)
  );

  // a zero sample divides by zero; its quotient is never used
  assign quo_chk = v_q[LAST-1] && !(flags_s[QUO_BITS].x_zero && flags_s[QUO_BITS].y_zero);

  `AAR_ASSERT(a_empty_out_opens, clk_i, rst_ni, !out_valid_o |-> in_ready_o)
  `AAR_ASSERT(a_accept_fills, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> v_q[0])
  `AAR_ASSERT(a_quo_max, clk_i, rst_ni, quo_chk |-> (quo_s[QUO_BITS] <= QUO_MAX))
  `AAR_ASSERT(a_angle_range, clk_i, rst_ni, out_valid_o |-> ((angle_o <= PI_Q) && (angle_o >= -PI_Q)))
  `AAR_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !out_valid_o)

endmodule
